>>> sv/bftr_pkg.sv
// ----------------------------------------------------------------------------
// bftr_pkg
// Shared constants and types of the bitmap font text rasterizer.
// ----------------------------------------------------------------------------
package bftr_pkg;

  localparam int GLYPH_COLUMNS = 8;
  localparam int GLYPH_ROWS    = 16;
  localparam int ROW_BITS_W    = 8;
  localparam int COL_W         = 3;
  localparam int ADDR_W        = 32;
  localparam int COORD_W       = 13;
  localparam int YP_W          = 28;
  localparam int PEN_W         = 16;
  localparam int WIDTH_W       = 15;
  localparam int COLOR_W       = 24;

  localparam logic [2:0] REG_FRAME_BASE    = 3'd0;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_LINE_PITCH    = 3'd3;
  localparam logic [2:0] REG_FONT_BASELINE = 3'd4;
  localparam logic [2:0] REG_GLYPH_GAP     = 3'd5;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [14:0] line_pitch;
    logic [4:0]  font_baseline;
    logic [3:0]  glyph_gap;
  } cfg_t;

  typedef struct packed {
    logic [GLYPH_COLUMNS-1:0] mask;
    logic [COLOR_W-1:0]       color;
    logic                     done;
    logic [WIDTH_W-1:0]       width;
    logic [YP_W-1:0]          yp;
  } row_t;

endpackage

>>> sv/bftr_front.sv
// ----------------------------------------------------------------------------
// bftr_front
// Accepts glyph rows, keeps the pen, clips rows and builds the row offset.
// ----------------------------------------------------------------------------
module bftr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bftr_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          first_of_text,
  input  logic [12:0]                   text_x,
  input  logic [12:0]                   text_y,
  input  logic [7:0]                    row_bits,
  input  logic [3:0]                    row_index,
  input  logic [3:0]                    glyph_width,
  input  logic                          last_row_of_glyph,
  input  logic                          last_of_text,
  input  logic [23:0]                   draw_color,
  input  logic                          buf_free,
  output logic                          load_s2,
  output logic [bftr_pkg::PEN_W-1:0]    px,
  output logic                          s2_valid,
  output bftr_pkg::row_t                s2_row
);
  import bftr_pkg::*;

  logic                     accept;
  logic                     s2_ready;
  logic [3:0]               gw_c;
  logic [PEN_W-1:0]         pen_cur;
  logic [12:0]              start_cur;
  logic [PEN_W-1:0]         pen_nxt;
  logic [12:0]              start_nxt;
  logic [13:0]              y14;
  logic                     y_ok;
  logic                     row_ok;
  logic [GLYPH_COLUMNS-1:0] col_mask;
  logic [WIDTH_W-1:0]       width_c;

  logic [PEN_W-1:0]         pen_r;
  logic [12:0]              start_r;
  logic                     s1_v_r, s1_v_nxt;
  logic                     s2_v_r, s2_v_nxt;
  logic [PEN_W-1:0]         s1_px_r;
  logic [COORD_W-1:0]       s1_y_r;
  logic [GLYPH_COLUMNS-1:0] s1_mask_r;
  logic [COLOR_W-1:0]       s1_color_r;
  logic                     s1_done_r;
  logic [WIDTH_W-1:0]       s1_width_r;
  row_t                     s2_r;

  assign s2_ready = !s2_v_r || buf_free;
  assign in_ready = !s1_v_r || s2_ready;
  assign load_s2  = s1_v_r && s2_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    gw_c      = (glyph_width > 4'(GLYPH_COLUMNS)) ? 4'(GLYPH_COLUMNS) : glyph_width;
    pen_cur   = first_of_text ? {{(PEN_W-13){text_x[12]}}, text_x} : pen_r;
    start_cur = first_of_text ? text_x : start_r;
    y14       = {text_y[12], text_y} - {9'd0, cfg.font_baseline} +
                {10'd0, row_index};
    y_ok      = !y14[13] && (y14[12:0] < cfg.screen_height);
    row_ok    = 6'(row_index) < 6'(GLYPH_ROWS);
    for (int c = 0; c < GLYPH_COLUMNS; c++) begin
      col_mask[c] = row_bits[ROW_BITS_W-1-c] && (4'(c) < gw_c) && y_ok && row_ok;
    end
    pen_nxt   = last_row_of_glyph ?
                (pen_cur + {12'd0, gw_c} + {12'd0, cfg.glyph_gap}) : pen_cur;
    start_nxt = start_cur;
    width_c   = pen_nxt[WIDTH_W-1:0] - {{(WIDTH_W-13){start_cur[12]}}, start_cur};
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (load_s2) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (load_s2) begin
      s2_v_nxt = 1'b1;
    end else if (buf_free) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r   <= '0;
      start_r <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      if (accept) begin
        pen_r   <= pen_nxt;
        start_r <= start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r    <= pen_cur;
      s1_y_r     <= y14[COORD_W-1:0];
      s1_mask_r  <= col_mask;
      s1_color_r <= draw_color;
      s1_done_r  <= last_of_text;
      s1_width_r <= width_c;
    end
    if (load_s2) begin
      s2_r.mask  <= s1_mask_r;
      s2_r.color <= s1_color_r;
      s2_r.done  <= s1_done_r;
      s2_r.width <= s1_width_r;
      s2_r.yp    <= {{(YP_W-COORD_W){1'b0}}, s1_y_r} *
                    {{(YP_W-15){1'b0}}, cfg.line_pitch};
    end
  end

  assign px       = s1_px_r;
  assign s2_valid = s2_v_r;
  assign s2_row   = s2_r;

endmodule

>>> sv/bftr_lane.sv
// ----------------------------------------------------------------------------
// bftr_lane
// One glyph column: clips its x and forms the pixel byte address.
// ----------------------------------------------------------------------------
module bftr_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [bftr_pkg::COL_W-1:0]    col,
  input  logic [bftr_pkg::PEN_W-1:0]    px,
  input  logic [12:0]                   screen_width,
  input  logic [31:0]                   frame_base,
  input  logic [bftr_pkg::YP_W-1:0]     yp,
  output logic                          ok,
  output logic [bftr_pkg::ADDR_W-1:0]   addr
);
  import bftr_pkg::*;

  logic [PEN_W:0]       x17;
  logic                 x_ok;
  logic [COORD_W-1:0]   x_r;
  logic                 ok_r;
  logic [COORD_W+1:0]   x3;

  always_comb begin
    x17  = {px[PEN_W-1], px} + {{(PEN_W+1-COL_W){1'b0}}, col};
    x_ok = !x17[PEN_W] && (x17[PEN_W-1:0] < {3'd0, screen_width});
    x3   = {1'b0, x_r, 1'b0} + {2'b0, x_r};
    addr = frame_base + {{(ADDR_W-YP_W){1'b0}}, yp} +
           {{(ADDR_W-COORD_W-2){1'b0}}, x3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (load) begin
      ok_r <= x_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x17[COORD_W-1:0];
    end
  end

  assign ok = ok_r;

endmodule

>>> sv/bftr_merge.sv
// ----------------------------------------------------------------------------
// bftr_merge
// Collects the lane results of one row and sends them out in column order.
// ----------------------------------------------------------------------------
module bftr_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            s2_valid,
  input  bftr_pkg::row_t                                  s2_row,
  input  logic [bftr_pkg::GLYPH_COLUMNS-1:0]              lane_ok,
  input  logic [bftr_pkg::GLYPH_COLUMNS-1:0][bftr_pkg::ADDR_W-1:0] lane_addr,
  output logic                                            buf_free,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic                                            result_kind,
  output logic [31:0]                                     pixel_address,
  output logic [7:0]                                      pixel_blue,
  output logic [7:0]                                      pixel_green,
  output logic [7:0]                                      pixel_red,
  output logic [14:0]                                     text_width,
  output logic                                            last_result
);
  import bftr_pkg::*;

  logic [GLYPH_COLUMNS:0]                  pend_r, pend_nxt;
  logic [GLYPH_COLUMNS-1:0][ADDR_W-1:0]    addr_r;
  logic [COLOR_W-1:0]                      color_r;
  logic [WIDTH_W-1:0]                      width_r;
  logic [GLYPH_COLUMNS:0]                  pick;
  logic [GLYPH_COLUMNS:0]                  rest;
  logic [ADDR_W-1:0]                       addr_sel;
  logic                                    take;
  logic                                    load;

  always_comb begin
    pick     = pend_r & (~pend_r + 1'b1);
    rest     = pend_r & ~pick;
    addr_sel = '0;
    for (int c = 0; c < GLYPH_COLUMNS; c++) begin
      addr_sel = addr_sel | (addr_r[c] & {ADDR_W{pick[c]}});
    end
    out_valid = pend_r != '0;
    take      = out_valid && out_ready;
    buf_free  = !out_valid || (take && (rest == '0));
    load      = s2_valid && buf_free;
    pend_nxt  = pend_r;
    if (load) begin
      pend_nxt = {s2_row.done, s2_row.mask & lane_ok};
    end else if (take) begin
      pend_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r  <= lane_addr;
      color_r <= s2_row.color;
      width_r <= s2_row.width;
    end
  end

  always_comb begin
    result_kind   = pick[GLYPH_COLUMNS];
    pixel_address = result_kind ? '0 : addr_sel;
    pixel_blue    = result_kind ? 8'd0 : color_r[7:0];
    pixel_green   = result_kind ? 8'd0 : color_r[15:8];
    pixel_red     = result_kind ? 8'd0 : color_r[23:16];
    text_width    = result_kind ? width_r : 15'd0;
    last_result   = rest == '0;
  end

endmodule

>>> sv/bitmap_font_text_rasterizer.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_rasterizer
// Turns glyph rows into 24-bit framebuffer pixel writes and text widths.
// A row passes through the input stage, the second stage with the lane
// registers, and the merge buffer before its first result appears. A row
// has up to nine results, one result per cycle at the output port while
// out_tready is high; rows without results produce no output. Reset clears
// the pen, all valid state and loads the register defaults.
// ----------------------------------------------------------------------------
module bitmap_font_text_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: text_x[12:0], text_y[25:13], row_bits[33:26], row_index[37:34],
  //        glyph_width[41:38], draw_color[65:42], zero fill[71:66]
  input  logic [71:0] in_tdata,
  // tuser: first_of_text[0], last_row_of_glyph[1]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: pixel_address[31:0], pixel_blue[39:32], pixel_green[47:40],
  //        pixel_red[55:48], text_width[70:56], zero fill[71]
  output logic [71:0] out_tdata,
  // tuser: result_kind[0]
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bftr_pkg::*;

  cfg_t                                 cfg_r;
  logic                                 wr_en;
  logic [2:0]                           reg_idx;
  logic                                 buf_free;
  logic                                 load_s2;
  logic [PEN_W-1:0]                     px;
  logic                                 s2_valid;
  row_t                                 s2_row;
  logic [GLYPH_COLUMNS-1:0]             lane_ok;
  logic [GLYPH_COLUMNS-1:0][ADDR_W-1:0] lane_addr;
  logic                                 result_kind;
  logic [31:0]                          pixel_address;
  logic [7:0]                           pixel_blue;
  logic [7:0]                           pixel_green;
  logic [7:0]                           pixel_red;
  logic [14:0]                          text_width;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_base    <= 32'd0;
      cfg_r.screen_width  <= 13'd1024;
      cfg_r.screen_height <= 13'd768;
      cfg_r.line_pitch    <= 15'd3072;
      cfg_r.font_baseline <= 5'd12;
      cfg_r.glyph_gap     <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_BASE:    cfg_r.frame_base    <= cfg_pwdata;
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_pwdata[12:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_pwdata[12:0];
        REG_LINE_PITCH:    cfg_r.line_pitch    <= cfg_pwdata[14:0];
        REG_FONT_BASELINE: cfg_r.font_baseline <= cfg_pwdata[4:0];
        REG_GLYPH_GAP:     cfg_r.glyph_gap     <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_BASE:    cfg_prdata = cfg_r.frame_base;
      REG_SCREEN_WIDTH:  cfg_prdata = {19'd0, cfg_r.screen_width};
      REG_SCREEN_HEIGHT: cfg_prdata = {19'd0, cfg_r.screen_height};
      REG_LINE_PITCH:    cfg_prdata = {17'd0, cfg_r.line_pitch};
      REG_FONT_BASELINE: cfg_prdata = {27'd0, cfg_r.font_baseline};
      REG_GLYPH_GAP:     cfg_prdata = {28'd0, cfg_r.glyph_gap};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  bftr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_tvalid),
    .in_ready          (in_tready),
    .first_of_text     (in_tuser[0]),
    .text_x            (in_tdata[12:0]),
    .text_y            (in_tdata[25:13]),
    .row_bits          (in_tdata[33:26]),
    .row_index         (in_tdata[37:34]),
    .glyph_width       (in_tdata[41:38]),
    .last_row_of_glyph (in_tuser[1]),
    .last_of_text      (in_tlast),
    .draw_color        (in_tdata[65:42]),
    .buf_free          (buf_free),
    .load_s2           (load_s2),
    .px                (px),
    .s2_valid          (s2_valid),
    .s2_row            (s2_row)
  );

  for (genvar g = 0; g < GLYPH_COLUMNS; g++) begin : g_lane
    bftr_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .load         (load_s2),
      .col          (COL_W'(g)),
      .px           (px),
      .screen_width (cfg_r.screen_width),
      .frame_base   (cfg_r.frame_base),
      .yp           (s2_row.yp),
      .ok           (lane_ok[g]),
      .addr         (lane_addr[g])
    );
  end

  bftr_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .s2_valid      (s2_valid),
    .s2_row        (s2_row),
    .lane_ok       (lane_ok),
    .lane_addr     (lane_addr),
    .buf_free      (buf_free),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .result_kind   (result_kind),
    .pixel_address (pixel_address),
    .pixel_blue    (pixel_blue),
    .pixel_green   (pixel_green),
    .pixel_red     (pixel_red),
    .text_width    (text_width),
    .last_result   (out_tlast)
  );

  assign out_tuser = result_kind;
  assign out_tdata = {1'b0, text_width, pixel_red, pixel_green, pixel_blue, pixel_address};

endmodule
